@@ design/rsel_pkg.sv @@
// ----------------------------------------------------------------------------
// Rectangle selection tracker package
// Shared sizes, request and status codes, and the structs passed between the
// configuration block, the selection engine and the top level.
// ----------------------------------------------------------------------------
package rsel_pkg;

  // Sheet limits and the coordinate widths that follow from them.
  localparam int MAX_COLS = 256;
  localparam int MAX_ROWS = 4096;
  localparam int MAX_TABS = 16;

  localparam int COL_W = $clog2(MAX_COLS);
  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int TAB_W = (MAX_TABS > 1) ? $clog2(MAX_TABS) : 1;

  // Size registers hold the count itself, so they are one bit wider.
  localparam int COLS_CFG_W = COL_W + 1;
  localparam int ROWS_CFG_W = ROW_W + 1;
  localparam int TABS_CFG_W = TAB_W + 1;
  localparam int CFG_DATA_W = (ROWS_CFG_W > COLS_CFG_W) ?
                              ((ROWS_CFG_W > TABS_CFG_W) ? ROWS_CFG_W : TABS_CFG_W) :
                              ((COLS_CFG_W > TABS_CFG_W) ? COLS_CFG_W : TABS_CFG_W);
  localparam int CFG_IDX_W  = 2;
  localparam int REQ_W      = 4;
  localparam int STATUS_W   = 3;

  // Request codes; codes eleven and up behave as a probe.
  localparam logic [REQ_W-1:0] REQ_START     = 4'd0;
  localparam logic [REQ_W-1:0] REQ_EXTEND    = 4'd1;
  localparam logic [REQ_W-1:0] REQ_SET       = 4'd2;
  localparam logic [REQ_W-1:0] REQ_FIRST     = 4'd3;
  localparam logic [REQ_W-1:0] REQ_NEXT      = 4'd4;
  localparam logic [REQ_W-1:0] REQ_CLEAR     = 4'd5;
  localparam logic [REQ_W-1:0] REQ_SAVE      = 4'd6;
  localparam logic [REQ_W-1:0] REQ_RESTORE   = 4'd7;
  localparam logic [REQ_W-1:0] REQ_WHOLECOLS = 4'd8;
  localparam logic [REQ_W-1:0] REQ_WHOLEROWS = 4'd9;
  localparam logic [REQ_W-1:0] REQ_PROBE     = 4'd10;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ILLEGAL  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_LIVE = 3'd2;
  localparam logic [STATUS_W-1:0] ST_WRONG_TAB = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ORDER    = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SHEET_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHEET_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHEET_TABS = 2'd2;

  // Selection record; also the layout of the saved copy.
  typedef struct packed {
    logic             mode;
    logic [TAB_W-1:0] otab;
    logic [COL_W-1:0] ocol;
    logic [ROW_W-1:0] orow;
    logic [COL_W-1:0] bcol;
    logic [ROW_W-1:0] brow;
    logic [COL_W-1:0] ecol;
    logic [ROW_W-1:0] erow;
    logic [COL_W-1:0] ccol;
    logic [ROW_W-1:0] crow;
    logic             fin;
  } sel_t;

  // Request data fields, last field in the lowest bits.
  typedef struct packed {
    logic             grow_mode;
    logic [ROW_W-1:0] end_row;
    logic [COL_W-1:0] end_col;
    logic [ROW_W-1:0] cell_row;
    logic [COL_W-1:0] cell_col;
    logic [TAB_W-1:0] cell_tab;
  } req_data_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    req_data_t        data;
  } req_t;

  // Result data fields, last field in the lowest bits.
  typedef struct packed {
    logic             scan_done;
    logic [ROW_W-1:0] pos_row;
    logic [COL_W-1:0] pos_col;
    logic [ROW_W-1:0] range_erow;
    logic [COL_W-1:0] range_ecol;
    logic [ROW_W-1:0] range_brow;
    logic [COL_W-1:0] range_bcol;
    logic [TAB_W-1:0] range_tab;
    logic             is_origin;
    logic             in_selection;
    logic             is_live;
  } res_data_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    res_data_t           data;
  } res_t;

  // Sheet configuration as seen by the engine.
  typedef struct packed {
    logic [COLS_CFG_W-1:0] cols;
    logic [ROWS_CFG_W-1:0] rows;
    logic [TABS_CFG_W-1:0] tabs;
    logic [COL_W-1:0]      last_col;
    logic [ROW_W-1:0]      last_row;
  } cfg_t;

  localparam int IN_FIELDS_W  = $bits(req_data_t);
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = $bits(res_data_t);
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [COLS_CFG_W-1:0] COLS_RESET = COLS_CFG_W'(MAX_COLS);
  localparam logic [ROWS_CFG_W-1:0] ROWS_RESET = ROWS_CFG_W'(MAX_ROWS);
  localparam logic [TABS_CFG_W-1:0] TABS_RESET = TABS_CFG_W'(MAX_TABS);

  // Last legal column for a size: zero for an empty sheet, clamped to the limit.
  function automatic logic [COL_W-1:0] last_col_of(input logic [COLS_CFG_W-1:0] size);
    logic [COL_W-1:0] v;
    if (size == '0) begin
      v = '0;
    end else if (size >= COLS_CFG_W'(MAX_COLS)) begin
      v = COL_W'(MAX_COLS - 1);
    end else begin
      v = COL_W'(size - COLS_CFG_W'(1));
    end
    return v;
  endfunction

  // Last legal row for a size, same rule as for columns.
  function automatic logic [ROW_W-1:0] last_row_of(input logic [ROWS_CFG_W-1:0] size);
    logic [ROW_W-1:0] v;
    if (size == '0) begin
      v = '0;
    end else if (size >= ROWS_CFG_W'(MAX_ROWS)) begin
      v = ROW_W'(MAX_ROWS - 1);
    end else begin
      v = ROW_W'(size - ROWS_CFG_W'(1));
    end
    return v;
  endfunction

  // A cell is legal when every coordinate is below both the sheet size and the limit.
  function automatic logic cell_legal(input cfg_t cfg,
                                      input logic [TAB_W-1:0] t,
                                      input logic [COL_W-1:0] c,
                                      input logic [ROW_W-1:0] r);
    logic ok;
    ok = (TABS_CFG_W'(t) < cfg.tabs) && (TABS_CFG_W'(t) < TABS_CFG_W'(MAX_TABS)) &&
         (COLS_CFG_W'(c) < cfg.cols) && (COLS_CFG_W'(c) < COLS_CFG_W'(MAX_COLS)) &&
         (ROWS_CFG_W'(r) < cfg.rows) && (ROWS_CFG_W'(r) < ROWS_CFG_W'(MAX_ROWS));
    return ok;
  endfunction

endpackage

@@ design/rsel_cfg.sv @@
// ----------------------------------------------------------------------------
// Sheet configuration registers
// Holds the sheet sizes and precomputes the last legal row and column used
// by the whole-row and whole-column requests.
// ----------------------------------------------------------------------------
module rsel_cfg
  import rsel_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  // Writes are always accepted.
  assign cfg_ready = 1'b1;

  // Register file; writes to unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cols     <= COLS_RESET;
      cfg.rows     <= ROWS_RESET;
      cfg.tabs     <= TABS_RESET;
      cfg.last_col <= last_col_of(COLS_RESET);
      cfg.last_row <= last_row_of(ROWS_RESET);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SHEET_COLS: begin
          cfg.cols     <= COLS_CFG_W'(cfg_data);
          cfg.last_col <= last_col_of(COLS_CFG_W'(cfg_data));
        end
        CFG_SHEET_ROWS: begin
          cfg.rows     <= ROWS_CFG_W'(cfg_data);
          cfg.last_row <= last_row_of(ROWS_CFG_W'(cfg_data));
        end
        CFG_SHEET_TABS: begin
          cfg.tabs <= TABS_CFG_W'(cfg_data);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ design/rsel_engine.sv @@
// ----------------------------------------------------------------------------
// Selection engine
// Holds the live selection and its saved copy, and works out the next state
// and the result for one request in a single combinational pass.
// ----------------------------------------------------------------------------
module rsel_engine
  import rsel_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic step,
  input  req_t req,
  input  cfg_t cfg,
  output res_t res
);

  logic live;
  logic live_next;
  sel_t cur;
  sel_t cur_next;
  sel_t saved;
  sel_t saved_next;

  logic begin_legal;
  logic end_legal;

  assign begin_legal = cell_legal(cfg, req.data.cell_tab, req.data.cell_col,
                                  req.data.cell_row);
  assign end_legal   = cell_legal(cfg, req.data.cell_tab, req.data.end_col,
                                  req.data.end_row);

  // Request decode, state update and result assembly.
  always_comb begin
    logic [STATUS_W-1:0] status;
    logic                pos_set;
    logic                done_set;
    logic [COL_W-1:0]    pc;
    logic [ROW_W-1:0]    pr;
    logic                done;
    logic [COL_W:0]      nc;
    logic [ROW_W:0]      nr;
    logic [TAB_W-1:0]    t;
    logic [COL_W-1:0]    c;
    logic [ROW_W-1:0]    r;

    t          = req.data.cell_tab;
    c          = req.data.cell_col;
    r          = req.data.cell_row;
    live_next  = live;
    cur_next   = cur;
    saved_next = saved;
    status     = ST_OK;
    pos_set    = 1'b0;
    done_set   = 1'b0;
    pc         = '0;
    pr         = '0;
    done       = 1'b0;
    nc         = '0;
    nr         = '0;

    unique case (req.req_type)
      REQ_START: begin
        if (!begin_legal) begin
          status = ST_ILLEGAL;
        end else begin
          live_next     = 1'b1;
          cur_next.mode = req.data.grow_mode;
          cur_next.otab = t;
          cur_next.ocol = c;
          cur_next.bcol = c;
          cur_next.ecol = c;
          cur_next.ccol = c;
          cur_next.orow = r;
          cur_next.brow = r;
          cur_next.erow = r;
          cur_next.crow = r;
          cur_next.fin  = 1'b0;
        end
      end
      REQ_EXTEND: begin
        if (!live) begin
          status = ST_NOT_LIVE;
        end else if (t != cur.otab) begin
          status = ST_WRONG_TAB;
        end else if (!begin_legal) begin
          status = ST_ILLEGAL;
        end else begin
          if (cur.mode) begin
            // Cumulative: grow the bounding box to cover the cell.
            if (c > cur.ecol) cur_next.ecol = c;
            if (c < cur.bcol) cur_next.bcol = c;
            if (r > cur.erow) cur_next.erow = r;
            if (r < cur.brow) cur_next.brow = r;
          end else begin
            // Anchored: span from the origin to the cell.
            if (c >= cur.ocol) begin
              cur_next.bcol = cur.ocol;
              cur_next.ecol = c;
            end else begin
              cur_next.bcol = c;
              cur_next.ecol = cur.ocol;
            end
            if (r >= cur.orow) begin
              cur_next.brow = cur.orow;
              cur_next.erow = r;
            end else begin
              cur_next.brow = r;
              cur_next.erow = cur.orow;
            end
          end
          cur_next.ccol = c;
          cur_next.crow = r;
          cur_next.fin  = 1'b0;
        end
      end
      REQ_SET: begin
        // The old selection is saved and cleared before the checks.
        saved_next = cur;
        live_next  = 1'b0;
        cur_next   = '0;
        if (!begin_legal || !end_legal) begin
          status = ST_ILLEGAL;
        end else if ((c > req.data.end_col) || (r > req.data.end_row)) begin
          status = ST_ORDER;
        end else begin
          live_next     = 1'b1;
          cur_next.mode = 1'b1;
          cur_next.otab = t;
          cur_next.ocol = c;
          cur_next.bcol = c;
          cur_next.ccol = c;
          cur_next.ecol = req.data.end_col;
          cur_next.orow = r;
          cur_next.brow = r;
          cur_next.crow = r;
          cur_next.erow = req.data.end_row;
          cur_next.fin  = 1'b0;
        end
      end
      REQ_FIRST: begin
        pos_set  = 1'b1;
        done_set = 1'b1;
        if (!live) begin
          pc   = c;
          pr   = r;
          done = 1'b1;
        end else begin
          cur_next.ccol = cur.bcol;
          cur_next.crow = cur.brow;
          cur_next.fin  = 1'b0;
          pc            = cur.bcol;
          pr            = cur.brow;
        end
      end
      REQ_NEXT: begin
        pos_set  = 1'b1;
        done_set = 1'b1;
        if (!live || cur.fin) begin
          done = 1'b1;
        end else begin
          // Row-major step with wrap to the left column of the next row.
          nc = {1'b0, cur.ccol} + 1'b1;
          nr = {1'b0, cur.crow};
          if (nc > {1'b0, cur.ecol}) begin
            nc = {1'b0, cur.bcol};
            nr = {1'b0, cur.crow} + 1'b1;
          end
          if (nr > {1'b0, cur.erow}) begin
            cur_next.fin  = 1'b1;
            cur_next.ccol = '0;
            cur_next.crow = '0;
            done          = 1'b1;
          end else begin
            cur_next.ccol = nc[COL_W-1:0];
            cur_next.crow = nr[ROW_W-1:0];
            pc            = nc[COL_W-1:0];
            pr            = nr[ROW_W-1:0];
          end
        end
      end
      REQ_CLEAR: begin
        pos_set = 1'b1;
        if (live) begin
          pc = cur.ocol;
          pr = cur.orow;
        end else begin
          pc = c;
          pr = r;
        end
        saved_next = cur;
        live_next  = 1'b0;
        cur_next   = '0;
      end
      REQ_SAVE: begin
        saved_next = cur;
      end
      REQ_RESTORE: begin
        cur_next  = saved;
        live_next = 1'b1;
        pos_set   = 1'b1;
        pc        = saved.fin ? '0 : saved.ccol;
        pr        = saved.fin ? '0 : saved.crow;
      end
      REQ_WHOLECOLS: begin
        cur_next.brow = '0;
        cur_next.erow = cfg.last_row;
      end
      REQ_WHOLEROWS: begin
        cur_next.bcol = '0;
        cur_next.ecol = cfg.last_col;
      end
      default: begin
        // Probe and the unused codes leave the state alone.
      end
    endcase

    if (!pos_set) begin
      pc = cur_next.fin ? '0 : cur_next.ccol;
      pr = cur_next.fin ? '0 : cur_next.crow;
    end
    if (!done_set) begin
      done = !live_next || cur_next.fin;
    end

    res.status            = status;
    res.data.is_live      = live_next;
    res.data.in_selection = live_next && (t == cur_next.otab) &&
                            (c >= cur_next.bcol) && (c <= cur_next.ecol) &&
                            (r >= cur_next.brow) && (r <= cur_next.erow);
    res.data.is_origin    = live_next && (t == cur_next.otab) &&
                            (c == cur_next.ocol) && (r == cur_next.orow);
    res.data.range_tab    = live_next ? cur_next.otab : t;
    res.data.range_bcol   = live_next ? cur_next.bcol : c;
    res.data.range_brow   = live_next ? cur_next.brow : r;
    res.data.range_ecol   = live_next ? cur_next.ecol : c;
    res.data.range_erow   = live_next ? cur_next.erow : r;
    res.data.pos_col      = pc;
    res.data.pos_row      = pr;
    res.data.scan_done    = done;
  end

  // Selection state advances once per processed request.
  always_ff @(posedge clk) begin
    if (rst) begin
      live  <= 1'b0;
      cur   <= '0;
      saved <= '0;
    end else if (step) begin
      live  <= live_next;
      cur   <= cur_next;
      saved <= saved_next;
    end
  end

  // The live flag reported with a result is the one the block keeps.
  a_live_tracks_result: assert property (@(posedge clk) disable iff (rst)
    step |=> (live == $past(res.data.is_live)))
    else $error("live flag differs from the reported is_live");

  // A clear always leaves the selection idle.
  a_clear_idles: assert property (@(posedge clk) disable iff (rst)
    (step && (req.req_type == REQ_CLEAR)) |=> !live)
    else $error("selection still live after clear");

  // A restore always leaves the selection live.
  a_restore_lives: assert property (@(posedge clk) disable iff (rst)
    (step && (req.req_type == REQ_RESTORE)) |=> live)
    else $error("selection not live after restore");

  // A start on an illegal cell changes nothing.
  a_bad_start_holds: assert property (@(posedge clk) disable iff (rst)
    (step && (req.req_type == REQ_START) && (res.status == ST_ILLEGAL))
      |=> ($stable(live) && $stable(cur)))
    else $error("illegal start changed the selection");

endmodule

@@ design/rect_selection_tracker_top.sv @@
// ----------------------------------------------------------------------------
// Rectangle selection tracker
// Requests enter on the s_ stream, one result per request leaves on the m_
// stream, and sheet sizes are written on the cfg_ channel.
//
// Each request is registered at the input, runs through the selection
// engine in one pass and lands in the output register that drives m_.
// The engine state updates as the result is registered, so a request
// can follow in the very next cycle, and while the receiver does not
// stall one transaction per cycle is sustained.
// When the receiver stalls, the output register holds its result and the
// input register holds one more request; s_tready falls only when both are
// full. Reset empties both registers, zeroes the selection and its saved
// copy, and loads the full sheet sizes.
// Configuration writes are always accepted; the user must make them only
// while no request is in flight, which the block does not enforce.
// ----------------------------------------------------------------------------
module rect_selection_tracker_top
  import rsel_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  // Requests. s_tdata fields from bit 0: cell_tab, cell_col, cell_row,
  // end_col, end_row, grow_mode. s_tuser: req_type.
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [REQ_W-1:0]       s_tuser,
  // Results. m_tdata fields from bit 0: is_live, in_selection, is_origin,
  // range_tab, range_bcol, range_brow, range_ecol, range_erow, pos_col,
  // pos_row, scan_done. m_tuser: status.
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic [STATUS_W-1:0]    m_tuser,
  // Configuration writes.
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg;
  req_t req_q;
  logic in_valid;
  res_t res;
  res_t res_q;
  logic out_valid;
  logic advance;

  rsel_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rsel_engine u_engine (
    .clk  (clk),
    .rst  (rst),
    .step (advance),
    .req  (req_q),
    .cfg  (cfg),
    .res  (res)
  );

  // A request moves on when the output register is free or being emptied.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      req_q.req_type <= s_tuser;
      req_q.data     <= s_tdata[IN_FIELDS_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = res_q.status;
  assign m_tdata  = OUT_TDATA_W'(res_q.data);

endmodule
